// ===== sv/dfsoc_pkg.sv =====
package dfsoc_pkg;

   localparam int NODES       = 64;
   localparam int NODE_W      = 6;
   localparam int ROW_IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int STACK_DEPTH = 64;
   localparam int STK_AW      = 6;
   localparam int DEPTH_W     = 7;
   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;

   localparam logic [NODE_W:0] NODES_EXT = (NODE_W + 1)'(NODES);

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_EDGE   = 2'd1,
      MODE_ENTRY  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_WR_A,
      ST_EDGE_WR_B,
      ST_ENTRY,
      ST_TOP_RD,
      ST_ROW_CHK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 adj_we;
      logic [ROW_IDX_W-1:0] adj_waddr;
      logic [NODES-1:0]     adj_wdata;
      logic [ROW_IDX_W-1:0] adj_raddr;
      logic                 stk_we;
      logic [STK_AW-1:0]    stk_waddr;
      logic [ROW_IDX_W-1:0] stk_wdata;
      logic [STK_AW-1:0]    stk_raddr;
   } mem_req_type;

endpackage

// ===== sv/dfs_order_checker.sv =====
// DFS order checker. Graph items and permutation entries arrive on the req_ stream: tuser
// carries the mode (clear graph, add edge, permutation entry), tdata the two node numbers,
// tlast marks the final entry of a sequence. The verdict (1 = valid depth-first order) is
// returned on the rsp_ stream, one item per entry marked last. A graph clear only resets the
// row valid bits; an edge is a read-modify-write of both adjacency rows (one for a self loop).
// A permutation entry after the first reads the stack top from the node stack RAM (registered
// read), then that node's adjacency row, and pops finished nodes one by one until the entry
// fits or the check fails; the verdict follows the last entry. Rows carry valid bits, so no
// clearing pass is needed after reset.
module dfs_order_checker
   import dfsoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // node_a[5:0], node_b[11:6], zero[15:12]
   input  logic [MODE_W-1:0]     req_tuser,  // mode[1:0]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // is_dfs_order[0], zero[7:1]
);

   mem_req_type          mem_req;
   logic [NODES-1:0]     adj_rdata;
   logic [ROW_IDX_W-1:0] stk_rdata;

   dfsoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mem_req    (mem_req),
      .adj_rdata  (adj_rdata),
      .stk_rdata  (stk_rdata)
   );

   dfsoc_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (mem_req.adj_we),
      .wr_addr (mem_req.adj_waddr),
      .wr_data (mem_req.adj_wdata),
      .rd_addr (mem_req.adj_raddr),
      .rd_data (adj_rdata)
   );

   dfsoc_ram #(
      .WIDTH (ROW_IDX_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_req.stk_we),
      .wr_addr (mem_req.stk_waddr),
      .wr_data (mem_req.stk_wdata),
      .rd_addr (mem_req.stk_raddr),
      .rd_data (stk_rdata)
   );

endmodule

// ===== sv/dfsoc_ram.sv =====
module dfsoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== sv/dfsoc_ctrl.sv =====
module dfsoc_ctrl
   import dfsoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output mem_req_type           mem_req,
   input  logic [NODES-1:0]      adj_rdata,
   input  logic [ROW_IDX_W-1:0]  stk_rdata
);

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    node_a_ff, node_a_in;
   logic [NODE_W-1:0]    node_b_ff, node_b_in;
   logic                 last_ff, last_in;
   logic [NODES-1:0]     visited_ff, visited_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic                 started_ff, started_in;
   logic                 failed_ff, failed_in;
   logic [NODES-1:0]     adj_valid_ff, adj_valid_in;
   logic [ROW_IDX_W-1:0] adj_raddr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_bit_in;

   logic [NODE_W-1:0]    req_a;
   logic [NODE_W-1:0]    req_b;
   logic [ROW_IDX_W-1:0] a_idx;
   logic [ROW_IDX_W-1:0] b_idx;
   logic                 entry_in_range;
   logic [NODES-1:0]     row;
   logic [NODES-1:0]     open_set;
   logic [DEPTH_W-1:0]   depth_m1;
   logic [DEPTH_W-1:0]   depth_m2;
   state_type            done_state;

   assign req_a          = req_tdata[NODE_W-1:0];
   assign req_b          = req_tdata[2*NODE_W-1:NODE_W];
   assign a_idx          = node_a_ff[ROW_IDX_W-1:0];
   assign b_idx          = node_b_ff[ROW_IDX_W-1:0];
   assign entry_in_range = {1'b0, node_a_ff} < NODES_EXT;
   // rows never written since the last clear read as empty
   assign row            = adj_valid_ff[adj_raddr_ff] ? adj_rdata : '0;
   assign open_set       = row & ~visited_ff;
   assign depth_m1       = depth_ff - DEPTH_W'(1);
   assign depth_m2       = depth_ff - DEPTH_W'(2);
   assign done_state     = last_ff ? ST_FINISH : ST_IDLE;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         visited_ff   <= '0;
         depth_ff     <= '0;
         started_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         adj_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         started_ff   <= started_in;
         failed_ff    <= failed_in;
         adj_valid_ff <= adj_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_a_ff    <= node_a_in;
      node_b_ff    <= node_b_in;
      last_ff      <= last_in;
      adj_raddr_ff <= mem_req.adj_raddr;
      rsp_bit_ff   <= rsp_bit_in;
   end

   always_comb begin
      state_in     = state_ff;
      node_a_in    = node_a_ff;
      node_b_in    = node_b_ff;
      last_in      = last_ff;
      visited_in   = visited_ff;
      depth_in     = depth_ff;
      started_in   = started_ff;
      failed_in    = failed_ff;
      adj_valid_in = adj_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bit_in   = rsp_bit_ff;
      mem_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               node_a_in = req_a;
               node_b_in = req_b;
               last_in   = req_tlast;
               case (mode_type'(req_tuser))
                  MODE_CLEAR: begin
                     adj_valid_in = '0;
                  end
                  MODE_EDGE: begin
                     if ({1'b0, req_a} < NODES_EXT && {1'b0, req_b} < NODES_EXT) begin
                        mem_req.adj_raddr = req_a[ROW_IDX_W-1:0];
                        state_in          = ST_EDGE_WR_A;
                     end
                  end
                  MODE_ENTRY: begin
                     state_in = ST_ENTRY;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EDGE_WR_A: begin
            mem_req.adj_we    = 1'b1;
            mem_req.adj_waddr = a_idx;
            mem_req.adj_wdata = row | (NODES'(1) << b_idx);
            adj_valid_in[a_idx] = 1'b1;
            // a self loop is one write; skip the second pass
            if (a_idx == b_idx) begin
               state_in = ST_IDLE;
            end else begin
               mem_req.adj_raddr = b_idx;
               state_in          = ST_EDGE_WR_B;
            end
         end

         ST_EDGE_WR_B: begin
            mem_req.adj_we    = 1'b1;
            mem_req.adj_waddr = b_idx;
            mem_req.adj_wdata = row | (NODES'(1) << a_idx);
            adj_valid_in[b_idx] = 1'b1;
            state_in = ST_IDLE;
         end

         ST_ENTRY: begin
            state_in = done_state;
            if (!failed_ff) begin
               if (!entry_in_range) begin
                  failed_in = 1'b1;
               end else if (!started_ff) begin
                  started_in = 1'b1;
                  visited_in[a_idx] = 1'b1;
                  if (!depth_ff[DEPTH_W-1]) begin
                     mem_req.stk_we    = 1'b1;
                     mem_req.stk_waddr = depth_ff[STK_AW-1:0];
                     mem_req.stk_wdata = a_idx;
                     depth_in          = depth_ff + DEPTH_W'(1);
                  end
               end else if (depth_ff == '0) begin
                  failed_in = 1'b1;
               end else begin
                  mem_req.stk_raddr = depth_m1[STK_AW-1:0];
                  state_in          = ST_TOP_RD;
               end
            end
         end

         ST_TOP_RD: begin
            mem_req.adj_raddr = stk_rdata;
            state_in          = ST_ROW_CHK;
         end

         ST_ROW_CHK: begin
            if (open_set[a_idx]) begin
               visited_in[a_idx] = 1'b1;
               if (!depth_ff[DEPTH_W-1]) begin
                  mem_req.stk_we    = 1'b1;
                  mem_req.stk_waddr = depth_ff[STK_AW-1:0];
                  mem_req.stk_wdata = a_idx;
                  depth_in          = depth_ff + DEPTH_W'(1);
               end
               state_in = done_state;
            end else if (open_set != '0) begin
               failed_in = 1'b1;
               state_in  = done_state;
            end else begin
               // pop and look at the node below
               depth_in = depth_m1;
               if (depth_m1 == '0) begin
                  failed_in = 1'b1;
                  state_in  = done_state;
               end else begin
                  mem_req.stk_raddr = depth_m2[STK_AW-1:0];
                  state_in          = ST_TOP_RD;
               end
            end
         end

         ST_FINISH: begin
            // hold the verdict until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = !failed_ff;
               visited_in   = '0;
               depth_in     = '0;
               started_in   = 1'b0;
               failed_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== verif/tb_dfs_order_checker.sv =====
module tb_dfs_order_checker;
   timeunit 1ns;
   timeprecision 1ps;
   import dfsoc_pkg::*;

   localparam int ITEM_GOAL    = 550;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 150;
   localparam int REPORT_MAX   = 10;
   localparam int PLAN_ROWS    = 25;

   typedef enum logic [1:0] {
      BY_MODEL,
      IS_VALID,
      IS_INVALID
   } verdict_src_type;

   typedef struct packed {
      mode_type          mode;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic              last;
      verdict_src_type   want;
   } probe_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // node_a[5:0], node_b[11:6], zero[15:12]
   logic [MODE_W-1:0]     req_tuser  = '0;  // mode[1:0]
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // is_dfs_order[0], zero[7:1]

   // graph and traversal state tracked alongside the block
   logic [NODES-1:0]  g_adj [NODES] = '{default: '0};
   logic [NODES-1:0]  seen_mask     = '0;
   logic [NODE_W-1:0] path_stack [STACK_DEPTH];
   int                path_depth    = 0;
   bit                seq_open      = 1'b0;
   bit                seq_bad       = 1'b0;

   bit verdict_q[$];
   int err_cnt      = 0;
   int items_sent   = 0;
   bit burst_mode   = 1'b0;
   bit rsp_hold_req = 1'b0;

   // directed items: graph items, sequence corner cases, ignored items
   probe_row_type probe_plan [PLAN_ROWS] = '{
      '{MODE_ENTRY,  6'd0,  6'd0,  1'b1, IS_VALID},    // lone entry right after reset
      '{MODE_UNUSED, 6'd63, 6'd63, 1'b1, BY_MODEL},    // ignored, last too
      '{MODE_EDGE,   6'd0,  6'd1,  1'b1, BY_MODEL},    // last has no effect on edges
      '{MODE_EDGE,   6'd1,  6'd2,  1'b0, BY_MODEL},
      '{MODE_EDGE,   6'd63, 6'd0,  1'b0, BY_MODEL},
      '{MODE_EDGE,   6'd5,  6'd5,  1'b0, BY_MODEL},    // self loop
      '{MODE_EDGE,   6'd63, 6'd63, 1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd0,  6'd63, 1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd1,  6'd0,  1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd2,  6'd21, 1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd63, 6'd42, 1'b1, BY_MODEL},    // backtrack two levels
      '{MODE_ENTRY,  6'd0,  6'd0,  1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd2,  6'd0,  1'b1, BY_MODEL},    // skips open neighbors
      '{MODE_ENTRY,  6'd0,  6'd0,  1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd0,  6'd0,  1'b1, IS_INVALID},  // repeated node
      '{MODE_ENTRY,  6'd5,  6'd0,  1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd0,  6'd0,  1'b1, BY_MODEL},    // stack runs empty
      '{MODE_ENTRY,  6'd0,  6'd0,  1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd3,  6'd0,  1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd1,  6'd0,  1'b1, IS_INVALID},  // after failure
      '{MODE_ENTRY,  6'd0,  6'd0,  1'b0, BY_MODEL},
      '{MODE_CLEAR,  6'd63, 6'd63, 1'b1, BY_MODEL},    // clear inside a sequence
      '{MODE_UNUSED, 6'd0,  6'd0,  1'b0, BY_MODEL},
      '{MODE_ENTRY,  6'd1,  6'd63, 1'b1, BY_MODEL},
      '{MODE_ENTRY,  6'd63, 6'd63, 1'b1, BY_MODEL}
   };

   dfs_order_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void mark_visit(input logic [NODE_W-1:0] n);
      if (path_depth < STACK_DEPTH) begin
         path_stack[path_depth] = n;
         path_depth++;
      end
      seen_mask[n] = 1'b1;
   endfunction

   // advance the tracked state by one item; report the verdict it yields
   function automatic void apply_item(input mode_type mode, input logic [NODE_W-1:0] a, b,
                                      input logic last, output bit has_verdict,
                                      output bit verdict);
      logic [NODE_W-1:0] top;
      logic [NODES-1:0]  free_nbrs;
      bit                placed;
      has_verdict = 1'b0;
      verdict     = 1'b0;
      placed      = 1'b0;
      case (mode)
         MODE_CLEAR: begin
            foreach (g_adj[i]) g_adj[i] = '0;
         end
         MODE_EDGE: begin
            if (int'(a) < NODES && int'(b) < NODES) begin
               g_adj[a][b] = 1'b1;
               g_adj[b][a] = 1'b1;
            end
         end
         MODE_ENTRY: begin
            if (seq_bad) begin
               // keep failing until the sequence ends
            end else if (int'(a) >= NODES) begin
               seq_bad = 1'b1;
            end else if (!seq_open) begin
               seq_open = 1'b1;
               mark_visit(a);
            end else begin
               // pop finished nodes until the entry fits or the check fails
               while (path_depth > 0 && !placed && !seq_bad) begin
                  top       = path_stack[path_depth-1];
                  free_nbrs = g_adj[top] & ~seen_mask;
                  if (free_nbrs[a]) begin
                     mark_visit(a);
                     placed = 1'b1;
                  end else if (free_nbrs != '0) begin
                     seq_bad = 1'b1;
                  end else begin
                     path_depth--;
                  end
               end
               if (!placed) seq_bad = 1'b1;
            end
            if (last) begin
               has_verdict = 1'b1;
               verdict     = !seq_bad;
               seen_mask   = '0;
               path_depth  = 0;
               seq_open    = 1'b0;
               seq_bad     = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic note_failure(input string msg);
      err_cnt++;
      if (err_cnt <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic send_item(input mode_type mode, input logic [NODE_W-1:0] a, b,
                            input logic last, input verdict_src_type src = BY_MODEL);
      int gap;
      bit has_v;
      bit v;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {(REQ_DATA_W - 2*NODE_W)'(0), b, a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      apply_item(mode, a, b, last, has_v, v);
      if (has_v)
         verdict_q.insert(verdict_q.size(), (src == BY_MODEL) ? v : (src == IS_VALID));
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // drop valid and hold until every verdict has come back
   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            note_failure($sformatf("unexpected verdict item, data=%h", rsp_tdata));
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata !== RSP_DATA_W'(want))
               note_failure($sformatf("verdict mismatch: expected %h, got %h",
                                      RSP_DATA_W'(want), rsp_tdata));
         end
      end
   end

   initial begin
      int                round;
      int                n;
      int                extra;
      int                nseq;
      int                pick;
      int                p;
      int                p2;
      bit                big;
      logic [NODE_W-1:0] c;
      logic [NODE_W-1:0] top;
      logic [NODE_W-1:0] tmp;
      logic [NODES-1:0]  used;
      logic [NODES-1:0]  walk_seen;
      logic [NODES-1:0]  free_nbrs;
      logic [NODE_W-1:0] labels[$];
      logic [NODE_W-1:0] walk_stk[$];
      logic [NODE_W-1:0] walk_order[$];

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_plan[i])
         send_item(probe_plan[i].mode, probe_plan[i].node_a, probe_plan[i].node_b,
                   probe_plan[i].last, probe_plan[i].want);
      drain_verdicts();

      round = 0;
      while (items_sent < ITEM_GOAL) begin
         round++;
         burst_mode = (round == 3) || ($urandom_range(0, 5) == 0);
         // stall the result side while items keep flowing in
         if (round == 3) rsp_hold_req = 1'b1;
         if (round == 6) drain_verdicts();

         big = (round == 4) || ($urandom_range(0, 11) == 0);
         n   = big ? $urandom_range(24, NODES) : $urandom_range(2, 9);
         labels.delete();
         used = '0;
         while (labels.size() < n) begin
            c = NODE_W'($urandom);
            if (!used[c]) begin
               used[c] = 1'b1;
               labels.insert(labels.size(), c);
            end
         end

         // random tree over the labels, then extra edges (self loops included)
         send_item(MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom));
         for (int i = 1; i < n; i++)
            send_item(MODE_EDGE, labels[i], labels[$urandom_range(0, i-1)], 1'($urandom));
         extra = big ? $urandom_range(0, n/4) : $urandom_range(0, n);
         repeat (extra)
            send_item(MODE_EDGE, labels[$urandom_range(0, n-1)],
                      labels[$urandom_range(0, n-1)], 1'($urandom));

         nseq = big ? $urandom_range(1, 2) : $urandom_range(2, 5);
         repeat (nseq) begin
            // random depth-first walk over the current graph
            walk_order.delete();
            walk_stk.delete();
            walk_seen = '0;
            top = labels[$urandom_range(0, n-1)];
            walk_order.insert(walk_order.size(), top);
            walk_stk.insert(walk_stk.size(), top);
            walk_seen[top] = 1'b1;
            while (walk_stk.size() > 0) begin
               top       = walk_stk[walk_stk.size()-1];
               free_nbrs = g_adj[top] & ~walk_seen;
               if (free_nbrs == '0) begin
                  void'(walk_stk.pop_back());
               end else begin
                  pick = $urandom_range(0, $countones(free_nbrs) - 1);
                  for (int k = 0; k < NODES; k++) begin
                     if (free_nbrs[k]) begin
                        if (pick == 0) begin
                           tmp = NODE_W'(k);
                           walk_order.insert(walk_order.size(), tmp);
                           walk_stk.insert(walk_stk.size(), tmp);
                           walk_seen[k] = 1'b1;
                        end
                        pick--;
                     end
                  end
               end
            end

            // break some walks: swap, replace, repeat a node, or cut short
            if ($urandom_range(0, 9) < 4) begin
               p  = $urandom_range(0, walk_order.size() - 1);
               p2 = $urandom_range(0, walk_order.size() - 1);
               case ($urandom_range(0, 3))
                  0: begin
                     tmp            = walk_order[p];
                     walk_order[p]  = walk_order[p2];
                     walk_order[p2] = tmp;
                  end
                  1: walk_order[p] = NODE_W'($urandom);
                  2: walk_order.insert(walk_order.size(), walk_order[p]);
                  default: begin
                     while (walk_order.size() > p + 1) void'(walk_order.pop_back());
                  end
               endcase
            end

            foreach (walk_order[k]) begin
               if ($urandom_range(0, 29) == 0)
                  send_item(MODE_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                            1'($urandom));
               if (!big && $urandom_range(0, 59) == 0)
                  send_item(MODE_EDGE, labels[$urandom_range(0, n-1)],
                            labels[$urandom_range(0, n-1)], 1'($urandom));
               if (!big && $urandom_range(0, 99) == 0)
                  send_item(MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                            1'($urandom));
               send_item(MODE_ENTRY, walk_order[k], NODE_W'($urandom),
                         k == walk_order.size() - 1);
            end
         end
      end

      burst_mode = 1'b0;
      drain_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
